// ===== hdl/obb_pkg.sv =====
// ----------------------------------------------------------------------------
// obb_pkg
// widths, constants and the queue word type shared by the box overlap test
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int COORD_W            = 24;
   localparam int HALF_W             = 23;
   localparam int AXIS_W             = 16;
   localparam int DIFF_W             = COORD_W + 1;
   localparam int DOT_W              = 2 * AXIS_W;
   localparam int MAG_AXIS_W         = DOT_W;
   localparam int PPROD_W            = DIFF_W + AXIS_W;
   localparam int PROJ_W             = PPROD_W + 1;
   localparam int TERM_PROD_W        = MAG_AXIS_W + HALF_W;
   localparam int TERM_W             = TERM_PROD_W + 1;

   localparam int OBB_AXIS_FRAC_BITS = 14;

   localparam int QUEUE_DEPTH        = 4;
   localparam int FRONT_STAGES       = 1;
   localparam int BACK_STAGES        = 3;
   localparam int MAX_IN_FLIGHT      = FRONT_STAGES + QUEUE_DEPTH + BACK_STAGES;

   typedef struct packed {
      logic signed [DIFF_W-1:0] diff_x;
      logic signed [DIFF_W-1:0] diff_y;
      logic [HALF_W-1:0]        a_half_w;
      logic [HALF_W-1:0]        a_half_h;
      logic [HALF_W-1:0]        b_half_w;
      logic [HALF_W-1:0]        b_half_h;
      logic signed [AXIS_W-1:0] a_cos;
      logic signed [AXIS_W-1:0] a_sin;
      logic signed [AXIS_W-1:0] b_cos;
      logic signed [AXIS_W-1:0] b_sin;
      logic signed [DOT_W-1:0]  dot_cc;
      logic signed [DOT_W-1:0]  dot_ss;
      logic signed [DOT_W-1:0]  dot_sc;
      logic signed [DOT_W-1:0]  dot_cs;
   } obb_pair_type;

endpackage

// ===== hdl/obb_front.sv =====
// ----------------------------------------------------------------------------
// obb_front
// accepts a box pair, forms the centre difference and the axis cross terms
// ----------------------------------------------------------------------------
module obb_front
   import obb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [COORD_W-1:0] req_a_center_x,
   input  logic signed [COORD_W-1:0] req_a_center_y,
   input  logic [HALF_W-1:0]        req_a_half_width,
   input  logic [HALF_W-1:0]        req_a_half_height,
   input  logic signed [AXIS_W-1:0] req_a_axis_cos,
   input  logic signed [AXIS_W-1:0] req_a_axis_sin,
   input  logic signed [COORD_W-1:0] req_b_center_x,
   input  logic signed [COORD_W-1:0] req_b_center_y,
   input  logic [HALF_W-1:0]        req_b_half_width,
   input  logic [HALF_W-1:0]        req_b_half_height,
   input  logic signed [AXIS_W-1:0] req_b_axis_cos,
   input  logic signed [AXIS_W-1:0] req_b_axis_sin,
   input  logic                     queue_full,
   output logic                     push,
   output obb_pair_type             push_word
);

   logic         valid_ff, valid_in;
   obb_pair_type pair_ff, pair_in;
   logic         advance;

   assign advance   = !valid_ff || !queue_full;
   assign req_stall = !advance;
   assign push      = valid_ff && !queue_full;
   assign push_word = pair_ff;
   assign valid_in  = advance ? req_valid : valid_ff;

   always_comb begin
      pair_in.diff_x   = DIFF_W'(req_b_center_x) - DIFF_W'(req_a_center_x);
      pair_in.diff_y   = DIFF_W'(req_b_center_y) - DIFF_W'(req_a_center_y);
      pair_in.a_half_w = req_a_half_width;
      pair_in.a_half_h = req_a_half_height;
      pair_in.b_half_w = req_b_half_width;
      pair_in.b_half_h = req_b_half_height;
      pair_in.a_cos    = req_a_axis_cos;
      pair_in.a_sin    = req_a_axis_sin;
      pair_in.b_cos    = req_b_axis_cos;
      pair_in.b_sin    = req_b_axis_sin;
      pair_in.dot_cc   = DOT_W'(req_a_axis_cos) * DOT_W'(req_b_axis_cos);
      pair_in.dot_ss   = DOT_W'(req_a_axis_sin) * DOT_W'(req_b_axis_sin);
      pair_in.dot_sc   = DOT_W'(req_a_axis_sin) * DOT_W'(req_b_axis_cos);
      pair_in.dot_cs   = DOT_W'(req_a_axis_cos) * DOT_W'(req_b_axis_sin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid) begin
         pair_ff <= pair_in;
      end
   end

endmodule

// ===== hdl/obb_queue.sv =====
// ----------------------------------------------------------------------------
// obb_queue
// short first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
module obb_queue
   import obb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  obb_pair_type push_word,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output obb_pair_type head_word
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   obb_pair_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_word = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== hdl/obb_back.sv =====
// ----------------------------------------------------------------------------
// obb_back
// three-stage separating-axis evaluation on the four box axes
// ----------------------------------------------------------------------------
module obb_back
   import obb_pkg::*;
#(
   parameter int AXIS_FRAC_BITS = OBB_AXIS_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         queue_empty,
   input  obb_pair_type head_word,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_overlap
);

   localparam int LHS_W = PROJ_W + AXIS_FRAC_BITS;
   localparam int OWN_W = HALF_W + 2 * AXIS_FRAC_BITS;
   localparam int SUM_W = ((OWN_W > TERM_W) ? OWN_W : TERM_W) + 2;
   localparam int CMP_W = (LHS_W > SUM_W) ? LHS_W : SUM_W;

   logic adv1, adv2, adv3;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;

   // stage 1: axis dot magnitudes and centre projection products
   logic signed [DOT_W:0]     p_sum, q_sum;
   logic [MAG_AXIS_W-1:0]     p_ff, p_in, q_ff, q_in;
   logic signed [PPROD_W-1:0] m_xac_ff, m_xac_in, m_yas_ff, m_yas_in;
   logic signed [PPROD_W-1:0] m_yac_ff, m_yac_in, m_xas_ff, m_xas_in;
   logic signed [PPROD_W-1:0] m_xbc_ff, m_xbc_in, m_ybs_ff, m_ybs_in;
   logic signed [PPROD_W-1:0] m_ybc_ff, m_ybc_in, m_xbs_ff, m_xbs_in;
   logic [HALF_W-1:0]         h1_aw_ff, h1_ah_ff, h1_bw_ff, h1_bh_ff;
   logic [HALF_W-1:0]         h1_aw_in, h1_ah_in, h1_bw_in, h1_bh_in;

   // stage 2: projected distances and the other-box terms
   logic signed [PROJ_W-1:0]  s_0, s_1, s_2, s_3;
   logic [PROJ_W-1:0]         d0_ff, d0_in, d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic [TERM_PROD_W-1:0]    t_pbw_ff, t_pbw_in, t_qbh_ff, t_qbh_in;
   logic [TERM_PROD_W-1:0]    t_qbw_ff, t_qbw_in, t_pbh_ff, t_pbh_in;
   logic [TERM_PROD_W-1:0]    t_paw_ff, t_paw_in, t_qah_ff, t_qah_in;
   logic [TERM_PROD_W-1:0]    t_qaw_ff, t_qaw_in, t_pah_ff, t_pah_in;
   logic [HALF_W-1:0]         h2_aw_ff, h2_ah_ff, h2_bw_ff, h2_bh_ff;
   logic [HALF_W-1:0]         h2_aw_in, h2_ah_in, h2_bw_in, h2_bh_in;

   // stage 3: compare and result register
   logic [CMP_W-1:0]          lhs0, lhs1, lhs2, lhs3;
   logic [CMP_W-1:0]          rhs0, rhs1, rhs2, rhs3;
   logic                      overlap_ff, overlap_in;

   assign adv3 = !s3_valid_ff || !rsp_stall;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;
   assign pop  = !queue_empty && adv1;

   assign s1_valid_in = adv1 ? !queue_empty : s1_valid_ff;
   assign s2_valid_in = adv2 ? s1_valid_ff  : s2_valid_ff;
   assign s3_valid_in = adv3 ? s2_valid_ff  : s3_valid_ff;

   assign rsp_valid   = s3_valid_ff;
   assign rsp_overlap = overlap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_comb begin
      p_sum    = (DOT_W + 1)'(head_word.dot_cc) + (DOT_W + 1)'(head_word.dot_ss);
      q_sum    = (DOT_W + 1)'(head_word.dot_sc) - (DOT_W + 1)'(head_word.dot_cs);
      p_in     = MAG_AXIS_W'(p_sum[DOT_W] ? -p_sum : p_sum);
      q_in     = MAG_AXIS_W'(q_sum[DOT_W] ? -q_sum : q_sum);
      m_xac_in = PPROD_W'(head_word.diff_x) * PPROD_W'(head_word.a_cos);
      m_yas_in = PPROD_W'(head_word.diff_y) * PPROD_W'(head_word.a_sin);
      m_yac_in = PPROD_W'(head_word.diff_y) * PPROD_W'(head_word.a_cos);
      m_xas_in = PPROD_W'(head_word.diff_x) * PPROD_W'(head_word.a_sin);
      m_xbc_in = PPROD_W'(head_word.diff_x) * PPROD_W'(head_word.b_cos);
      m_ybs_in = PPROD_W'(head_word.diff_y) * PPROD_W'(head_word.b_sin);
      m_ybc_in = PPROD_W'(head_word.diff_y) * PPROD_W'(head_word.b_cos);
      m_xbs_in = PPROD_W'(head_word.diff_x) * PPROD_W'(head_word.b_sin);
      h1_aw_in = head_word.a_half_w;
      h1_ah_in = head_word.a_half_h;
      h1_bw_in = head_word.b_half_w;
      h1_bh_in = head_word.b_half_h;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p_ff     <= p_in;
         q_ff     <= q_in;
         m_xac_ff <= m_xac_in;
         m_yas_ff <= m_yas_in;
         m_yac_ff <= m_yac_in;
         m_xas_ff <= m_xas_in;
         m_xbc_ff <= m_xbc_in;
         m_ybs_ff <= m_ybs_in;
         m_ybc_ff <= m_ybc_in;
         m_xbs_ff <= m_xbs_in;
         h1_aw_ff <= h1_aw_in;
         h1_ah_ff <= h1_ah_in;
         h1_bw_ff <= h1_bw_in;
         h1_bh_ff <= h1_bh_in;
      end
   end

   always_comb begin
      s_0      = PROJ_W'(m_xac_ff) + PROJ_W'(m_yas_ff);
      s_1      = PROJ_W'(m_yac_ff) - PROJ_W'(m_xas_ff);
      s_2      = PROJ_W'(m_xbc_ff) + PROJ_W'(m_ybs_ff);
      s_3      = PROJ_W'(m_ybc_ff) - PROJ_W'(m_xbs_ff);
      d0_in    = s_0[PROJ_W-1] ? -s_0 : s_0;
      d1_in    = s_1[PROJ_W-1] ? -s_1 : s_1;
      d2_in    = s_2[PROJ_W-1] ? -s_2 : s_2;
      d3_in    = s_3[PROJ_W-1] ? -s_3 : s_3;
      t_pbw_in = TERM_PROD_W'(p_ff) * TERM_PROD_W'(h1_bw_ff);
      t_qbh_in = TERM_PROD_W'(q_ff) * TERM_PROD_W'(h1_bh_ff);
      t_qbw_in = TERM_PROD_W'(q_ff) * TERM_PROD_W'(h1_bw_ff);
      t_pbh_in = TERM_PROD_W'(p_ff) * TERM_PROD_W'(h1_bh_ff);
      t_paw_in = TERM_PROD_W'(p_ff) * TERM_PROD_W'(h1_aw_ff);
      t_qah_in = TERM_PROD_W'(q_ff) * TERM_PROD_W'(h1_ah_ff);
      t_qaw_in = TERM_PROD_W'(q_ff) * TERM_PROD_W'(h1_aw_ff);
      t_pah_in = TERM_PROD_W'(p_ff) * TERM_PROD_W'(h1_ah_ff);
      h2_aw_in = h1_aw_ff;
      h2_ah_in = h1_ah_ff;
      h2_bw_in = h1_bw_ff;
      h2_bh_in = h1_bh_ff;
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         d0_ff    <= d0_in;
         d1_ff    <= d1_in;
         d2_ff    <= d2_in;
         d3_ff    <= d3_in;
         t_pbw_ff <= t_pbw_in;
         t_qbh_ff <= t_qbh_in;
         t_qbw_ff <= t_qbw_in;
         t_pbh_ff <= t_pbh_in;
         t_paw_ff <= t_paw_in;
         t_qah_ff <= t_qah_in;
         t_qaw_ff <= t_qaw_in;
         t_pah_ff <= t_pah_in;
         h2_aw_ff <= h2_aw_in;
         h2_ah_ff <= h2_ah_in;
         h2_bw_ff <= h2_bw_in;
         h2_bh_ff <= h2_bh_in;
      end
   end

   always_comb begin
      lhs0 = CMP_W'(d0_ff) << AXIS_FRAC_BITS;
      lhs1 = CMP_W'(d1_ff) << AXIS_FRAC_BITS;
      lhs2 = CMP_W'(d2_ff) << AXIS_FRAC_BITS;
      lhs3 = CMP_W'(d3_ff) << AXIS_FRAC_BITS;
      rhs0 = (CMP_W'(h2_aw_ff) << (2 * AXIS_FRAC_BITS)) + CMP_W'(t_pbw_ff) + CMP_W'(t_qbh_ff);
      rhs1 = (CMP_W'(h2_ah_ff) << (2 * AXIS_FRAC_BITS)) + CMP_W'(t_qbw_ff) + CMP_W'(t_pbh_ff);
      rhs2 = (CMP_W'(h2_bw_ff) << (2 * AXIS_FRAC_BITS)) + CMP_W'(t_paw_ff) + CMP_W'(t_qah_ff);
      rhs3 = (CMP_W'(h2_bh_ff) << (2 * AXIS_FRAC_BITS)) + CMP_W'(t_qaw_ff) + CMP_W'(t_pah_ff);
      overlap_in = !((lhs0 > rhs0) || (lhs1 > rhs1) || (lhs2 > rhs2) || (lhs3 > rhs3));
   end

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         overlap_ff <= overlap_in;
      end
   end

endmodule

// ===== hdl/obb_obb_overlap_test.sv =====
// ----------------------------------------------------------------------------
// obb_obb_overlap_test
// separating-axis overlap test for a pair of 2d oriented boxes
// ----------------------------------------------------------------------------
//  channel   ports            direction   word
//  request   req_valid/stall  in          two boxes: centre, half extents, axis
//  response  rsp_valid/stall  out         overlap flag
//
//  one box pair accepted per cycle, one result per cycle while neither channel stalls
//  from acceptance to result a pair passes the front register, the queue, two
//  multiplier stages in the back part, then the compare into the result register
//  synchronous reset empties the front register, the queue and the back stages
//  the four-word queue absorbs response stalls; req_stall rises only when
//  the front register holds a word and the queue is full
// ----------------------------------------------------------------------------
module obb_obb_overlap_test
   import obb_pkg::*;
#(
   parameter int AXIS_FRAC_BITS = OBB_AXIS_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_a_center_x,
   input  logic signed [COORD_W-1:0] req_a_center_y,
   input  logic [HALF_W-1:0]         req_a_half_width,
   input  logic [HALF_W-1:0]         req_a_half_height,
   input  logic signed [AXIS_W-1:0]  req_a_axis_cos,
   input  logic signed [AXIS_W-1:0]  req_a_axis_sin,
   input  logic signed [COORD_W-1:0] req_b_center_x,
   input  logic signed [COORD_W-1:0] req_b_center_y,
   input  logic [HALF_W-1:0]         req_b_half_width,
   input  logic [HALF_W-1:0]         req_b_half_height,
   input  logic signed [AXIS_W-1:0]  req_b_axis_cos,
   input  logic signed [AXIS_W-1:0]  req_b_axis_sin,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_overlap
);

   logic         push, queue_full, queue_empty, pop;
   obb_pair_type push_word, head_word;

   obb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_a_center_x    (req_a_center_x),
      .req_a_center_y    (req_a_center_y),
      .req_a_half_width  (req_a_half_width),
      .req_a_half_height (req_a_half_height),
      .req_a_axis_cos    (req_a_axis_cos),
      .req_a_axis_sin    (req_a_axis_sin),
      .req_b_center_x    (req_b_center_x),
      .req_b_center_y    (req_b_center_y),
      .req_b_half_width  (req_b_half_width),
      .req_b_half_height (req_b_half_height),
      .req_b_axis_cos    (req_b_axis_cos),
      .req_b_axis_sin    (req_b_axis_sin),
      .queue_full        (queue_full),
      .push              (push),
      .push_word         (push_word)
   );

   obb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head_word (head_word)
   );

   obb_back #(
      .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_word   (head_word),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_overlap (rsp_overlap)
   );

endmodule

// ===== hdl/obb_checker.sv =====
// ----------------------------------------------------------------------------
// obb_checker
// port-level checks on word flow through the overlap test
// ----------------------------------------------------------------------------
module obb_checker
   import obb_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_overlap
);

   localparam int CNT_W = $clog2(MAX_IN_FLIGHT + 1);

   logic             in_take, out_take;
   logic [CNT_W-1:0] held_ff, held_in;

   assign in_take  = req_valid && !req_stall;
   assign out_take = rsp_valid && !rsp_stall;
   assign held_in  = held_ff + CNT_W'(in_take) - CNT_W'(out_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_overlap))
      else $error("stalled response word changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> held_ff != '0)
      else $error("response word without a request word");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(MAX_IN_FLIGHT))
      else $error("more words in flight than storage allows");

   a_empty_free: assert property (@(posedge clock) disable iff (reset)
      held_ff == '0 |-> !req_stall && !rsp_valid)
      else $error("empty block stalls or shows a response");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind obb_obb_overlap_test obb_checker u_obb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_overlap (rsp_overlap)
);

// ===== test/tb_obb_obb_overlap_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_obb_obb_overlap_test
// self-checking bench for the oriented box separating-axis test
// ----------------------------------------------------------------------------
//  box pairs are driven on the request channel and every accepted word is
//  run through a local overlap predictor; each result word is compared with
//  the oldest prediction. directed pairs cover touching, zero and non-unit
//  axes and field extremes, then random pairs mix near boxes, corner values
//  and raw bit patterns, all but one burst under random idling on both channels
// ----------------------------------------------------------------------------
module tb_obb_obb_overlap_test
   import obb_pkg::*;
;

   localparam int AXIS_FRAC    = OBB_AXIS_FRAC_BITS;
   localparam int STUCK_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 16;

   typedef struct {
      logic signed [COORD_W-1:0] a_cx, a_cy;
      logic [HALF_W-1:0]         a_hw, a_hh;
      logic signed [AXIS_W-1:0]  a_cos, a_sin;
      logic signed [COORD_W-1:0] b_cx, b_cy;
      logic [HALF_W-1:0]         b_hw, b_hh;
      logic signed [AXIS_W-1:0]  b_cos, b_sin;
   } box_pair_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [COORD_W-1:0] req_a_center_x = '0;
   logic signed [COORD_W-1:0] req_a_center_y = '0;
   logic [HALF_W-1:0]         req_a_half_width = '0;
   logic [HALF_W-1:0]         req_a_half_height = '0;
   logic signed [AXIS_W-1:0]  req_a_axis_cos = '0;
   logic signed [AXIS_W-1:0]  req_a_axis_sin = '0;
   logic signed [COORD_W-1:0] req_b_center_x = '0;
   logic signed [COORD_W-1:0] req_b_center_y = '0;
   logic [HALF_W-1:0]         req_b_half_width = '0;
   logic [HALF_W-1:0]         req_b_half_height = '0;
   logic signed [AXIS_W-1:0]  req_b_axis_cos = '0;
   logic signed [AXIS_W-1:0]  req_b_axis_sin = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_overlap;

   bit overlap_due[$];
   int req_idle_pct = 14;
   int rsp_idle_pct = 14;
   int n_pairs      = 0;
   int n_results    = 0;
   int n_overlap    = 0;
   int errors       = 0;
   int stuck_cycles = 0;

   obb_obb_overlap_test dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_a_center_x    (req_a_center_x),
      .req_a_center_y    (req_a_center_y),
      .req_a_half_width  (req_a_half_width),
      .req_a_half_height (req_a_half_height),
      .req_a_axis_cos    (req_a_axis_cos),
      .req_a_axis_sin    (req_a_axis_sin),
      .req_b_center_x    (req_b_center_x),
      .req_b_center_y    (req_b_center_y),
      .req_b_half_width  (req_b_half_width),
      .req_b_half_height (req_b_half_height),
      .req_b_axis_cos    (req_b_axis_cos),
      .req_b_axis_sin    (req_b_axis_sin),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_overlap       (rsp_overlap)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit axis_separates(longint proj, longint own, longint other);
      longint lhs;
      longint rhs;
      lhs = magnitude(proj) <<< AXIS_FRAC;
      rhs = (own <<< (2 * AXIS_FRAC)) + other;
      return lhs > rhs;
   endfunction

   function automatic bit boxes_overlap(box_pair_type w);
      longint dx, dy, ac, asn, bc, bsn, ahw, ahh, bhw, bhh, p, q;
      bit     apart;
      dx  = longint'(w.b_cx) - longint'(w.a_cx);
      dy  = longint'(w.b_cy) - longint'(w.a_cy);
      ac  = longint'(w.a_cos);
      asn = longint'(w.a_sin);
      bc  = longint'(w.b_cos);
      bsn = longint'(w.b_sin);
      ahw = longint'(w.a_hw);
      ahh = longint'(w.a_hh);
      bhw = longint'(w.b_hw);
      bhh = longint'(w.b_hh);
      // cross-axis dot products repeat in 2d, so two magnitudes suffice
      p = magnitude(ac * bc + asn * bsn);
      q = magnitude(asn * bc - ac * bsn);
      apart = axis_separates(dx * ac + dy * asn, ahw, p * bhw + q * bhh)
           || axis_separates(dy * ac - dx * asn, ahh, q * bhw + p * bhh)
           || axis_separates(dx * bc + dy * bsn, bhw, p * ahw + q * ahh)
           || axis_separates(dy * bc - dx * bsn, bhh, q * ahw + p * ahh);
      return !apart;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic box_pair_type box_pair(int acx, int acy, int ahw, int ahh, int ac,
                                             int asn, int bcx, int bcy, int bhw, int bhh,
                                             int bc, int bsn);
      box_pair_type w;
      w.a_cx  = COORD_W'(acx);
      w.a_cy  = COORD_W'(acy);
      w.a_hw  = HALF_W'(ahw);
      w.a_hh  = HALF_W'(ahh);
      w.a_cos = AXIS_W'(ac);
      w.a_sin = AXIS_W'(asn);
      w.b_cx  = COORD_W'(bcx);
      w.b_cy  = COORD_W'(bcy);
      w.b_hw  = HALF_W'(bhw);
      w.b_hh  = HALF_W'(bhh);
      w.b_cos = AXIS_W'(bc);
      w.b_sin = AXIS_W'(bsn);
      return w;
   endfunction

   function automatic int corner_val(int width, bit sgn);
      case ($urandom_range(4))
         0:       return 0;
         1:       return -1;
         2:       return sgn ? (1 << (width - 1)) : ((1 << width) - 1);
         3:       return sgn ? ((1 << (width - 1)) - 1) : 1;
         default: return int'($urandom);
      endcase
   endfunction

   function automatic box_pair_type random_pair();
      int  mode, ahw, ahh, bhw, bhh, span, acx, acy, dx, dy;
      int  ac, asn, bc, bsn;
      real ang;
      mode = $urandom_range(99);
      if (mode < 15) begin
         return box_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      if (mode < 30) begin
         return box_pair(corner_val(COORD_W, 1), corner_val(COORD_W, 1),
                         corner_val(HALF_W, 0), corner_val(HALF_W, 0),
                         corner_val(AXIS_W, 1), corner_val(AXIS_W, 1),
                         corner_val(COORD_W, 1), corner_val(COORD_W, 1),
                         corner_val(HALF_W, 0), corner_val(HALF_W, 0),
                         corner_val(AXIS_W, 1), corner_val(AXIS_W, 1));
      end
      // near boxes: offsets on the scale of the half extents
      ahw  = int'($urandom_range(0, 1 << $urandom_range(2, 18)));
      ahh  = int'($urandom_range(0, 1 << $urandom_range(2, 18)));
      bhw  = int'($urandom_range(0, 1 << $urandom_range(2, 18)));
      bhh  = int'($urandom_range(0, 1 << $urandom_range(2, 18)));
      span = ahw + ahh + bhw + bhh + 1;
      acx  = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      acy  = int'($urandom_range(0, 1 << 23)) - (1 << 22);
      dx   = int'($urandom_range(0, 3 * span)) - (3 * span) / 2;
      dy   = int'($urandom_range(0, 3 * span)) - (3 * span) / 2;
      if (mode < 40) begin
         ac  = ($urandom_range(1) != 0) ? 16384 : -16384;
         asn = 0;
         bc  = 0;
         bsn = ($urandom_range(1) != 0) ? 16384 : -16384;
      end else begin
         ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
         ac  = int'(16384.0 * $cos(ang));
         asn = int'(16384.0 * $sin(ang));
         ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
         bc  = int'(16384.0 * $cos(ang));
         bsn = int'(16384.0 * $sin(ang));
      end
      return box_pair(acx, acy, ahw, ahh, ac, asn, acx + dx, acy + dy, bhw, bhh, bc, bsn);
   endfunction

   task automatic send_pair(input box_pair_type w);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_a_center_x    <= w.a_cx;
      req_a_center_y    <= w.a_cy;
      req_a_half_width  <= w.a_hw;
      req_a_half_height <= w.a_hh;
      req_a_axis_cos    <= w.a_cos;
      req_a_axis_sin    <= w.a_sin;
      req_b_center_x    <= w.b_cx;
      req_b_center_y    <= w.b_cy;
      req_b_half_width  <= w.b_hw;
      req_b_half_height <= w.b_hh;
      req_b_axis_cos    <= w.b_cos;
      req_b_axis_sin    <= w.b_sin;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      // identical boxes, and all-zero fields
      send_pair(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(box_pair(0, 0, 256, 256, 16384, 0, 0, 0, 256, 256, 16384, 0));
      // exact touching along x and y, then one lsb apart
      send_pair(box_pair(0, 0, 256, 256, 16384, 0, 512, 0, 256, 256, 16384, 0));
      send_pair(box_pair(0, 0, 256, 256, 16384, 0, 513, 0, 256, 256, 16384, 0));
      send_pair(box_pair(0, 0, 256, 256, 16384, 0, 0, -512, 256, 256, 16384, 0));
      send_pair(box_pair(0, 0, 256, 256, 16384, 0, 0, -513, 256, 256, 16384, 0));
      // zero axes never separate
      send_pair(box_pair(-8388608, -8388608, 0, 0, 0, 0, 8388607, 8388607, 0, 0, 0, 0));
      send_pair(box_pair(-8388608, 0, 0, 0, 0, 0, 8388607, 0, 100, 100, 16384, 0));
      // points: coincident touch, distinct apart
      send_pair(box_pair(1000, -1000, 0, 0, 16384, 0, 1000, -1000, 0, 0, 0, 16384));
      send_pair(box_pair(1000, -1000, 0, 0, 16384, 0, 1001, -1000, 0, 0, 0, 16384));
      // field extremes
      send_pair(box_pair(-8388608, -8388608, 8388607, 8388607, 16384, 0,
                         8388607, 8388607, 8388607, 8388607, 0, 16384));
      send_pair(box_pair(-8388608, 0, 8388607, 0, 16384, 0, 8388607, 0, 8388607, 0, 16384, 0));
      send_pair(box_pair(0, -8388608, 0, 8388607, 16384, 0, 0, 8388607, 0, 8388607, -16384, 0));
      send_pair(box_pair(8388607, -8388608, 8388607, 8388607, -32768, 32767,
                         -8388608, 8388607, 8388607, 8388607, 32767, -32768));
      send_pair(box_pair(8388607, 8388607, 8388607, 8388607, -32768, -32768,
                         -8388608, -8388608, 8388607, 8388607, -32768, -32768));
      // non-unit axes keep own half extents unscaled
      send_pair(box_pair(0, 0, 256, 256, 32767, 0, 512, 0, 256, 256, 32767, 0));
      send_pair(box_pair(0, 0, 256, 256, 8192, 0, 600, 0, 256, 256, 8192, 0));
      // rotated boxes, near and clear
      send_pair(box_pair(0, 0, 2560, 256, 11585, 11585, 2048, 0, 256, 256, 16384, 0));
      send_pair(box_pair(0, 0, 2560, 256, 11585, 11585, 2048, -1200, 256, 256, 16384, 0));
      send_pair(box_pair(0, 0, 1024, 1024, 16384, 0, 1700, 1700, 512, 128, 11585, -11585));
      send_pair(box_pair(0, 0, 1024, 1024, 16384, 0, 1500, 1500, 512, 128, 11585, 11585));
      send_pair(box_pair(-300, 200, 700, 90, 14189, 8192, 500, 900, 300, 40, -8192, 14189));
   endtask

   task automatic test_random_mix(input int count);
      repeat (count) send_pair(random_pair());
   endtask

   task automatic test_no_idle_burst(input int count);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (count) send_pair(random_pair());
      req_idle_pct = 14;
      rsp_idle_pct = 14;
   endtask

   task automatic test_drain_pause(input int count);
      repeat (count) send_pair(random_pair());
      req_valid <= 1'b0;
      while (overlap_due.size() != 0) @(negedge clock);
      repeat (count) send_pair(random_pair());
   endtask

   // ---------------------------------------------------------------- checking

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin : monitor
      box_pair_type w;
      bit           want;
      bit           moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            moved = 1'b1;
            n_results++;
            if (rsp_overlap === 1'b1) n_overlap++;
            if (overlap_due.size() == 0) begin
               $error("unexpected result word: overlap %0b", rsp_overlap);
               errors++;
            end else begin
               want = overlap_due.pop_front();
               if (rsp_overlap !== want) begin
                  $error("overlap mismatch: expected %0b, actual %0b", want, rsp_overlap);
                  errors++;
               end
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            moved   = 1'b1;
            w.a_cx  = req_a_center_x;
            w.a_cy  = req_a_center_y;
            w.a_hw  = req_a_half_width;
            w.a_hh  = req_a_half_height;
            w.a_cos = req_a_axis_cos;
            w.a_sin = req_a_axis_sin;
            w.b_cx  = req_b_center_x;
            w.b_cy  = req_b_center_y;
            w.b_hw  = req_b_half_width;
            w.b_hh  = req_b_half_height;
            w.b_cos = req_b_axis_cos;
            w.b_sin = req_b_axis_sin;
            overlap_due = {overlap_due, boxes_overlap(w)};
            n_pairs++;
         end
         stuck_cycles = moved ? 0 : stuck_cycles + 1;
      end
   end

   initial begin
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_mix(700);
      test_no_idle_burst(400);
      test_drain_pause(150);
      test_random_mix(350);
      req_valid <= 1'b0;
      while (overlap_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("checked %0d box pairs: %0d overlapping, %0d apart, idling on both sides",
               n_pairs, n_overlap, n_results - n_overlap);
      if (errors == 0 && n_results == n_pairs) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
